/* hw/rtl/kth_ancestor_binary_lifting_assert.svh */
// Assertion macros for the k-th ancestor engine.
`ifndef KTH_ANCESTOR_BINARY_LIFTING_ASSERT_SVH
`define KTH_ANCESTOR_BINARY_LIFTING_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge while reset is released.
`define KTHANC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define KTHANC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KTHANC_ASSERT(lbl, clk, rst_n, prop, msg)
`define KTHANC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hw/rtl/kthanc_pkg.sv */
// Shared types and constants for the k-th ancestor engine.
`timescale 1ns / 1ps

package kthanc_pkg;

  localparam int FIELD_W       = 10;
  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 10;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [FIELD_W-1:0] node;
    logic [FIELD_W-1:0] parent_node;
    logic [FIELD_W-1:0] steps_up;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] ancestor;
  } out_t;

endpackage

/* hw/rtl/kth_ancestor_binary_lifting.sv */
// Binary lifting k-th ancestor engine: one shared jump-table read port under a sequencer.
// Load: accepted with start; busy while the jump levels are written, one jump level written per cycle
//   (a load of an out-of-range node, or with parent not below node, leaves busy low).
// Query: busy through a depth check, then one lifting level per cycle;
//   out_valid rises as busy drops, after the last level, or at the end of a failed depth check (or out-of-range node).
// The jump-table read port sets the pace; the receiver cannot stall out_valid.
// Synchronous active-low reset clears the sequencer; table contents are undefined until loaded.
`timescale 1ns / 1ps

`include "kth_ancestor_binary_lifting_assert.svh"

module kth_ancestor_binary_lifting #(
  parameter int MAX_NODES = kthanc_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = kthanc_pkg::LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  kthanc_pkg::in_t   in_data,
  output logic              out_valid,
  output kthanc_pkg::out_t  out_data
);

  import kthanc_pkg::*;

  localparam int IDX_W    = $clog2(MAX_NODES);
  localparam int DEP_W    = IDX_W;
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LCNT_W   = $clog2(LEVELS + 1);
  localparam int JT_AW    = IDX_W + LVL_W;
  localparam int JT_DEPTH = MAX_NODES << LVL_W;
  localparam int CMP_W    = (DEP_W > FIELD_W) ? DEP_W : FIELD_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_QCHK = 4'b0100,
    S_QRUN = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [LCNT_W-1:0]   lvl_r, lvl_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  logic [IDX_W-1:0]    v_r, p_r, cur_r, cur_nxt;
  logic [FIELD_W-1:0]  k_r;
  logic                root_r, oor_r, sel_r, sel_nxt;

  logic [IDX_W-1:0]    jt_mem [JT_DEPTH];
  logic [DEP_W-1:0]    dep_mem [MAX_NODES];
  logic [IDX_W-1:0]    jt_rd_r;
  logic [DEP_W-1:0]    dep_rd_r;

  logic                jt_we, dep_we;
  logic [JT_AW-1:0]    jt_waddr, jt_raddr;
  logic [IDX_W-1:0]    jt_wdata;
  logic [IDX_W-1:0]    dep_raddr;
  logic [DEP_W-1:0]    dep_wdata;

  logic                acc, in_oor, load_ok;
  logic [IDX_W-1:0]    in_node_i, in_par_i;
  logic [LVL_W-1:0]    lvl_idx;
  logic [IDX_W-1:0]    wdata, cur;
  logic [FIELD_W-1:0]  k_sh;
  logic [DEP_W:0]      dep_inc;
  logic [DEP_W-1:0]    dep_sat;
  logic                dep_fail;

  assign acc       = start && (state_r == S_IDLE);
  assign in_oor    = 32'(in_data.node) >= 32'(MAX_NODES);
  assign in_node_i = IDX_W'(in_data.node);
  assign in_par_i  = IDX_W'(in_data.parent_node);
  assign load_ok   = !in_oor &&
                     ((in_data.node == '0) || (in_data.parent_node < in_data.node));

  assign lvl_idx  = lvl_r[LVL_W-1:0];
  assign wdata    = root_r ? '0 : ((lvl_r == '0) ? p_r : jt_rd_r);
  assign cur      = sel_r ? jt_rd_r : cur_r;
  assign k_sh     = k_r >> lvl_r;
  assign dep_inc  = {1'b0, dep_rd_r} + (DEP_W+1)'(1);
  assign dep_sat  = (dep_inc > (DEP_W+1)'(MAX_NODES - 1)) ? DEP_W'(MAX_NODES - 1)
                                                         : dep_inc[DEP_W-1:0];
  assign dep_fail = CMP_W'(dep_rd_r) < CMP_W'(k_r);

  assign dep_raddr = (in_data.operation == OP_QUERY) ? in_node_i : in_par_i;
  assign jt_waddr  = {v_r, lvl_idx};
  assign jt_wdata  = wdata;
  assign jt_we     = (state_r == S_LOAD);
  assign dep_we    = (state_r == S_LOAD) && (lvl_r == '0);
  assign dep_wdata = root_r ? '0 : dep_sat;

  always_comb begin
    case (state_r)
      S_LOAD:  jt_raddr = {wdata, lvl_idx};
      S_QCHK:  jt_raddr = {v_r, {LVL_W{1'b0}}};
      S_QRUN:  jt_raddr = {cur, lvl_idx};
      default: jt_raddr = {v_r, lvl_idx};
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    cur_nxt       = cur_r;
    sel_nxt       = sel_r;
    case (state_r)
      S_IDLE: begin
        lvl_nxt = '0;
        if (acc) begin
          if (in_data.operation == OP_QUERY) begin
            state_nxt = S_QCHK;
          end else if (load_ok) begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        lvl_nxt = lvl_r + LCNT_W'(1);
        if (lvl_r == LCNT_W'(LEVELS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_QCHK: begin
        if (oor_r || dep_fail) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.found    = 1'b0;
          out_data_nxt.ancestor = '0;
          state_nxt             = S_IDLE;
        end else begin
          sel_nxt   = k_r[0];
          cur_nxt   = v_r;
          lvl_nxt   = LCNT_W'(1);
          state_nxt = S_QRUN;
        end
      end
      S_QRUN: begin
        if (lvl_r == LCNT_W'(LEVELS)) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.found    = 1'b1;
          out_data_nxt.ancestor = FIELD_W'(cur);
          state_nxt             = S_IDLE;
        end else begin
          sel_nxt = k_sh[0];
          cur_nxt = cur;
          lvl_nxt = lvl_r + LCNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    cur_r      <= cur_nxt;
    sel_r      <= sel_nxt;
    if (acc) begin
      v_r    <= in_node_i;
      p_r    <= in_par_i;
      k_r    <= in_data.steps_up;
      root_r <= (in_data.node == '0);
      oor_r  <= in_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (jt_we) begin
      jt_mem[jt_waddr] <= jt_wdata;
    end
    jt_rd_r <= jt_mem[jt_raddr];
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[v_r] <= dep_wdata;
    end
    dep_rd_r <= dep_mem[dep_raddr];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `KTHANC_ASSERT(a_out_from_query, clk, rst_n, out_valid_r |-> $past(state_r == S_QCHK || state_r == S_QRUN), "result beat without a query in flight")
  `KTHANC_ASSERT(a_out_single, clk, rst_n, out_valid_r |=> !out_valid_r, "result beat repeated")
  `KTHANC_ASSERT(a_notfound_zero, clk, rst_n, out_valid_r && !out_data_r.found |-> out_data_r.ancestor == '0, "ancestor nonzero on a miss")
  `KTHANC_ASSERT(a_query_busy, clk, rst_n, acc && in_data.operation == OP_QUERY |=> busy, "query accepted but engine idle")
  `KTHANC_ASSERT(a_load_lvl, clk, rst_n, state_r == S_LOAD |-> lvl_r < LCNT_W'(LEVELS), "load level past table width")

endmodule
